/* rtl/core/mul_div_register_unit_core_defines.svh */
// Assertion macros for the multiply/divide register unit.
// Needs only the clock and reset names that are passed in by the caller.
`ifndef MUL_DIV_REGISTER_UNIT_CORE_DEFINES_SVH
`define MUL_DIV_REGISTER_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define MDRU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mdru: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define MDRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mdru: next-cycle check failed");

`endif

/* rtl/core/mdru_pkg.sv */
// Package for the multiply/divide register unit: register addresses, bank codes,
// step counts and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package mdru_pkg;

    localparam logic [15:0] ADDR_WRMPYA = 16'h4202;
    localparam logic [15:0] ADDR_WRMPYB = 16'h4203;
    localparam logic [15:0] ADDR_WRDIVL = 16'h4204;
    localparam logic [15:0] ADDR_WRDIVH = 16'h4205;
    localparam logic [15:0] ADDR_WRDIVB = 16'h4206;
    localparam logic [15:0] ADDR_RDDIVL = 16'h4214;
    localparam logic [15:0] ADDR_RDDIVH = 16'h4215;
    localparam logic [15:0] ADDR_RDMPYL = 16'h4216;
    localparam logic [15:0] ADDR_RDMPYH = 16'h4217;

    localparam logic [7:0]  BANK_WRAM_LO = 8'h7E;
    localparam logic [7:0]  BANK_WRAM_HI = 8'h7F;

    localparam logic [15:0] DIV_ZERO_QUOTIENT = 16'hFFFF;

    localparam logic        KIND_READ  = 1'b0;
    localparam logic        KIND_WRITE = 1'b1;

    // Starting value of the down-counting step counter: 8 multiply bits, 16 divide bits.
    localparam logic [3:0]  MUL_LAST_STEP = 4'd7;
    localparam logic [3:0]  DIV_LAST_STEP = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_DIV  = 3'b100
    } state_t;

endpackage

/* rtl/core/mul_div_register_unit_core.sv */
// Multiply/divide register unit: bus-mapped 8x8 multiplier and 16/8 divider.
// Depends on mdru_pkg and mul_div_register_unit_core_defines.svh.
`timescale 1ns / 1ps
`include "mul_div_register_unit_core_defines.svh"

// Usage
//   Input channel (in_valid/in_stall) carries one bus access per beat: kind, bank,
//   address, write_data. Output channel (out_valid/out_stall) returns one beat per
//   access: read_data and claimed.
//   The result beat is registered in the cycle after the access is taken; reads see
//   the result registers as left by every earlier access.
//   Sequencing: a write to 0x4203 runs a shift-add multiply, one multiplier bit per
//   cycle; a write to 0x4206 runs a restoring divide, one quotient bit per cycle
//   (zero divisor finishes at once). in_stall is high while that sequencer runs, so
//   no new access is taken until the multiply or divide is done.
//   Banks 0x7E and 0x7F are never claimed and change nothing.
//   Receiver stall: the output register holds its beat; a new access is taken only
//   when that register is empty or being drained in the same cycle.
//   Reset (rst_n low, asynchronous): all result/operand registers clear to zero,
//   sequencer idle, output register empty.
module mul_div_register_unit_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [7:0]           bank,
    input  logic [15:0]          address,
    input  logic [7:0]           write_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           read_data,
    output logic                 claimed
);
    import mdru_pkg::*;

    state_t      state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic [7:0]  multiplicand_reg, multiplicand_next;
    logic [15:0] dividend_reg, dividend_next;
    logic [15:0] quotient_reg, quotient_next;
    logic [15:0] prod_rem_reg, prod_rem_next;     // product or remainder
    logic [7:0]  divisor_reg, divisor_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  read_data_reg, read_data_next;
    logic        claimed_reg, claimed_next;

    logic        in_fire;
    logic        out_fire;
    logic        bank_ok;
    logic        hit;
    logic [7:0]  rd_byte;

    // Datapath slices for one serial step
    logic [8:0]  mul_sum;
    logic [8:0]  div_trial;
    logic [8:0]  div_diff;
    logic        div_ge;

    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_fire  = in_valid && !in_stall;
    assign bank_ok  = (bank != BANK_WRAM_LO) && (bank != BANK_WRAM_HI);

    // Multiply: {acc, multiplier} shifts right; add multiplicand when the low bit is set.
    assign mul_sum   = {1'b0, prod_rem_reg[15:8]}
                     + {1'b0, (prod_rem_reg[0] ? multiplicand_reg : 8'd0)};
    // Divide: shift next dividend bit into the partial remainder and trial-subtract.
    assign div_trial = {prod_rem_reg[7:0], quotient_reg[15]};
    assign div_diff  = div_trial - {1'b0, divisor_reg};
    assign div_ge    = (div_trial >= {1'b0, divisor_reg});

    // Address decode and read mux
    always_comb
    begin
        hit     = 1'b0;
        rd_byte = 8'd0;
        if (kind == KIND_WRITE)
        begin
            unique case (address)
                ADDR_WRMPYA, ADDR_WRMPYB, ADDR_WRDIVL,
                ADDR_WRDIVH, ADDR_WRDIVB: hit = 1'b1;
                default:                  hit = 1'b0;
            endcase
        end
        else
        begin
            unique case (address)
                ADDR_RDDIVL:
                begin
                    hit     = 1'b1;
                    rd_byte = quotient_reg[7:0];
                end
                ADDR_RDDIVH:
                begin
                    hit     = 1'b1;
                    rd_byte = quotient_reg[15:8];
                end
                ADDR_RDMPYL:
                begin
                    hit     = 1'b1;
                    rd_byte = prod_rem_reg[7:0];
                end
                ADDR_RDMPYH:
                begin
                    hit     = 1'b1;
                    rd_byte = prod_rem_reg[15:8];
                end
                default:
                begin
                    hit     = 1'b0;
                    rd_byte = 8'd0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        multiplicand_next = multiplicand_reg;
        dividend_next     = dividend_reg;
        quotient_next     = quotient_reg;
        prod_rem_next     = prod_rem_reg;
        divisor_next      = divisor_reg;
        out_valid_next    = out_valid_reg && !out_fire;
        read_data_next    = read_data_reg;
        claimed_next      = claimed_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    out_valid_next = 1'b1;
                    claimed_next   = bank_ok && hit;
                    read_data_next = (bank_ok && kind == KIND_READ) ? rd_byte : 8'd0;
                    if (bank_ok && kind == KIND_WRITE)
                    begin
                        unique case (address)
                            ADDR_WRMPYA: multiplicand_next = write_data;
                            ADDR_WRMPYB:
                            begin
                                prod_rem_next = {8'd0, write_data};
                                quotient_next = 16'd0;
                                step_next     = MUL_LAST_STEP;
                                state_next    = ST_MUL;
                            end
                            ADDR_WRDIVL: dividend_next = {dividend_reg[15:8], write_data};
                            ADDR_WRDIVH: dividend_next = {write_data, dividend_reg[7:0]};
                            ADDR_WRDIVB:
                            begin
                                if (write_data == 8'd0)
                                begin
                                    quotient_next = DIV_ZERO_QUOTIENT;
                                    prod_rem_next = dividend_reg;
                                end
                                else
                                begin
                                    quotient_next = dividend_reg;
                                    prod_rem_next = 16'd0;
                                    divisor_next  = write_data;
                                    step_next     = DIV_LAST_STEP;
                                    state_next    = ST_DIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ST_MUL:
            begin
                prod_rem_next = {mul_sum, prod_rem_reg[7:1]};
                step_next     = step_reg - 4'd1;
                if (step_reg == 4'd0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                prod_rem_next = {8'd0, (div_ge ? div_diff[7:0] : div_trial[7:0])};
                quotient_next = {quotient_reg[14:0], div_ge};
                step_next     = step_reg - 4'd1;
                if (step_reg == 4'd0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= 4'd0;
            multiplicand_reg <= 8'd0;
            dividend_reg     <= 16'd0;
            quotient_reg     <= 16'd0;
            prod_rem_reg     <= 16'd0;
            divisor_reg      <= 8'd0;
            out_valid_reg    <= 1'b0;
            read_data_reg    <= 8'd0;
            claimed_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            multiplicand_reg <= multiplicand_next;
            dividend_reg     <= dividend_next;
            quotient_reg     <= quotient_next;
            prod_rem_reg     <= prod_rem_next;
            divisor_reg      <= divisor_next;
            out_valid_reg    <= out_valid_next;
            read_data_reg    <= read_data_next;
            claimed_reg      <= claimed_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign claimed   = claimed_reg;

    // Checks
    `MDRU_ASSERT_IMPLY(a_busy_stalls, clk, rst_n, state_reg != ST_IDLE, in_stall)
    `MDRU_ASSERT_NEXT(a_accept_loads_out, clk, rst_n, in_fire, out_valid_reg)
    `MDRU_ASSERT_NEXT(a_div_zero, clk, rst_n,
        in_fire && bank_ok && kind == KIND_WRITE && address == ADDR_WRDIVB && write_data == 8'd0,
        quotient_reg == DIV_ZERO_QUOTIENT && state_reg == ST_IDLE)
    `MDRU_ASSERT_NEXT(a_seq_ends, clk, rst_n,
        state_reg != ST_IDLE && step_reg == 4'd0, state_reg == ST_IDLE)

endmodule
